// ===== rtl/core/sal_pkg.sv =====
// ----------------------------------------------------------------------------
// sal_pkg: shared types and codes of the shifting array list
// Command and status codes, the per-cell shift control and the sweep carry
// that travels down the row of cells during search and read.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam int DEPTH_DEFAULT = 64;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_BACK  = 3'd4,
        CMD_REM_AT    = 3'd5,
        CMD_SEARCH    = 3'd6,
        CMD_READ      = 3'd7
    } sal_cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } sal_status_t;

    // shift control broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [WORD_W-1:0] word;
    } sal_ctrl_t;

    // sweep carry handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] data;
    } sal_carry_t;

endpackage

// ===== rtl/core/shifting_array_list.sv =====
// ----------------------------------------------------------------------------
// shifting_array_list: ordered list of signed words held in a row of cells
// Insert and remove shift all cells in parallel; search and read run as a
// registered sweep down the row, one cell per cycle.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  command | s_valid s_ready s_cmd s_value s_position     | in
//  result  | m_valid m_ready m_status m_found m_count     | out
//          | m_read_value                                 |
//
//  insert and remove commands may follow back to back; search and read hold
//  the command side until the carry has walked through the DEPTH cells one
//  register per cycle.
//  commands are taken only while the result register is free or being drained.
//  aresetn empties the list (count zero); entry contents are not cleared.
// ----------------------------------------------------------------------------
module shifting_array_list #(
    parameter int DEPTH = sal_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sal_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [sal_pkg::WORD_W-1:0] s_value,
    input  logic [sal_pkg::POS_W-1:0]    s_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sal_pkg::STATUS_W-1:0] m_status,
    output logic                         m_found,
    output logic [sal_pkg::COUNT_W-1:0]  m_count,
    output logic signed [sal_pkg::WORD_W-1:0] m_read_value
);
    import sal_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SWP_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SWP_W-1:0]   sweep_reg, sweep_next;
    logic [WORD_W-1:0]  key_value_reg, key_value_next;
    logic [POS_W-1:0]   key_pos_reg, key_pos_next;
    logic               is_read_reg, is_read_next;
    sal_status_t        qstat_reg, qstat_next;

    logic               m_valid_reg, m_valid_next;
    sal_status_t        m_status_reg, m_status_next;
    logic               m_found_reg, m_found_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic [WORD_W-1:0]  m_read_value_reg, m_read_value_next;

    logic               out_free;
    logic               accept;
    logic               full;
    logic               empty;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   cnt_new_ext;
    logic [CMP_W-1:0]   shift_pos;
    logic               ins_ok;
    logic               rem_ok;
    logic               dec_ok;
    logic               is_query;
    sal_status_t        mod_status;
    sal_status_t        read_status;
    sal_ctrl_t          ctrl;

    logic [WORD_W-1:0]  entry_w [DEPTH];
    sal_carry_t         carry_w [DEPTH+1];

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(s_position);
    assign cnt_ext = CMP_W'(count_reg);

    // command decode and status checks
    always_comb begin
        shift_pos   = '0;
        ins_ok      = 1'b0;
        rem_ok      = 1'b0;
        dec_ok      = 1'b0;
        is_query    = 1'b0;
        mod_status  = STAT_OK;
        read_status = STAT_OK;
        unique case (sal_cmd_t'(s_cmd))
            CMD_INS_FRONT: begin
                if (full) mod_status = STAT_FULL;
                else      ins_ok     = 1'b1;
            end
            CMD_INS_BACK: begin
                shift_pos = cnt_ext;
                if (full) mod_status = STAT_FULL;
                else      ins_ok     = 1'b1;
            end
            CMD_INS_AT: begin
                shift_pos = pos_ext;
                if (full)                   mod_status = STAT_FULL;
                else if (pos_ext > cnt_ext) mod_status = STAT_BADPOS;
                else                        ins_ok     = 1'b1;
            end
            CMD_REM_FRONT: begin
                if (empty) mod_status = STAT_EMPTY;
                else       rem_ok     = 1'b1;
            end
            CMD_REM_BACK: begin
                if (empty) mod_status = STAT_EMPTY;
                else       dec_ok     = 1'b1;
            end
            CMD_REM_AT: begin
                shift_pos = pos_ext;
                if (empty)                   mod_status = STAT_EMPTY;
                else if (pos_ext >= cnt_ext) mod_status = STAT_BADPOS;
                else                         rem_ok     = 1'b1;
            end
            CMD_SEARCH: begin
                is_query = 1'b1;
            end
            CMD_READ: begin
                is_query = 1'b1;
                if (empty)                   read_status = STAT_EMPTY;
                else if (pos_ext >= cnt_ext) read_status = STAT_BADPOS;
            end
            default: begin
                is_query = 1'b1;
            end
        endcase
    end

    // shift control to the cells, only on an accepted transfer
    always_comb begin
        ctrl.ins  = accept && ins_ok;
        ctrl.rem  = accept && rem_ok;
        ctrl.word = s_value;
    end

    always_comb begin
        count_next = count_reg;
        if (accept && ins_ok) begin
            count_next = count_reg + 1'b1;
        end else if (accept && (rem_ok || dec_ok)) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign cnt_new_ext = CMP_W'(count_next);

    // sequencer and result register
    always_comb begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        key_value_next    = key_value_reg;
        key_pos_next      = key_pos_reg;
        is_read_next      = is_read_reg;
        qstat_next        = qstat_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_found_next      = m_found_reg;
        m_count_next      = m_count_reg;
        m_read_value_next = m_read_value_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_query) begin
                        key_value_next = s_value;
                        key_pos_next   = s_position;
                        is_read_next   = (sal_cmd_t'(s_cmd) == CMD_READ);
                        qstat_next     = read_status;
                        sweep_next     = SWP_W'(DEPTH - 1);
                        state_next     = ST_SWEEP;
                    end else begin
                        m_valid_next      = 1'b1;
                        m_status_next     = mod_status;
                        m_found_next      = 1'b0;
                        m_count_next      = cnt_new_ext[COUNT_W-1:0];
                        m_read_value_next = '0;
                    end
                end
            end
            ST_SWEEP: begin
                sweep_next = sweep_reg - 1'b1;
                if (sweep_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_count_next  = cnt_ext[COUNT_W-1:0];
                    state_next    = ST_IDLE;
                    if (is_read_reg) begin
                        m_status_next     = qstat_reg;
                        m_found_next      = 1'b0;
                        m_read_value_next = (qstat_reg == STAT_OK) ?
                                            carry_w[DEPTH].data : '0;
                    end else begin
                        m_status_next     = STAT_OK;
                        m_found_next      = carry_w[DEPTH].found;
                        m_read_value_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sweep_reg        <= sweep_next;
        key_value_reg    <= key_value_next;
        key_pos_reg      <= key_pos_next;
        is_read_reg      <= is_read_next;
        qstat_reg        <= qstat_next;
        m_status_reg     <= m_status_next;
        m_found_reg      <= m_found_next;
        m_count_reg      <= m_count_next;
        m_read_value_reg <= m_read_value_next;
    end

    // row of cells
    assign carry_w[0] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = ctrl.word;
        end else begin : g_mid_l
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = entry_w[i];
        end else begin : g_mid_r
            assign right_w = entry_w[i+1];
        end

        sal_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .shift_pos   (shift_pos),
            .key_value   (key_value_reg),
            .key_pos     (CMP_W'(key_pos_reg)),
            .key_count   (cnt_ext),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .carry_in    (carry_w[i]),
            .carry_out   (carry_w[i+1])
        );
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_count      = m_count_reg;
    assign m_read_value = m_read_value_reg;

endmodule

// ===== rtl/core/sal_cell.sv =====
// ----------------------------------------------------------------------------
// sal_cell: one slot of the shifting array list
// Holds one entry, shifts up or down with its neighbors on insert and remove,
// and adds its own compare and read-out to the sweep carry every cycle.
// ----------------------------------------------------------------------------
module sal_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = 7
) (
    input  logic                       aclk,
    input  sal_pkg::sal_ctrl_t         ctrl,
    input  logic [CMP_W-1:0]           shift_pos,
    input  logic [sal_pkg::WORD_W-1:0] key_value,
    input  logic [CMP_W-1:0]           key_pos,
    input  logic [CMP_W-1:0]           key_count,
    input  logic [sal_pkg::WORD_W-1:0] left_entry,
    input  logic [sal_pkg::WORD_W-1:0] right_entry,
    output logic [sal_pkg::WORD_W-1:0] entry,
    input  sal_pkg::sal_carry_t        carry_in,
    output sal_pkg::sal_carry_t        carry_out
);
    import sal_pkg::*;

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;
    sal_carry_t        carry_reg;
    sal_carry_t        carry_next;

    // shift up on insert, shift down on remove, else hold
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (IDX == shift_pos) begin
                entry_next = ctrl.word;
            end else if (IDX > shift_pos) begin
                entry_next = left_entry;
            end
        end else if (ctrl.rem && (IDX >= shift_pos)) begin
            entry_next = right_entry;
        end
    end

    // local compare and read-out folded into the carry
    always_comb begin
        carry_next.found = carry_in.found | ((IDX < key_count) && (entry_reg == key_value));
        carry_next.data  = (IDX == key_pos) ? entry_reg : carry_in.data;
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        carry_reg <= carry_next;
    end

    assign entry     = entry_reg;
    assign carry_out = carry_reg;

endmodule

// ===== tb/tb_shifting_array_list.sv =====
// ----------------------------------------------------------------------------
// tb_shifting_array_list: self-checking bench for the shifting array list
// Drives list commands over the s_ valid/ready channel and checks every
// m_ transfer against an in-bench list predictor. The run covers the empty
// and full boundaries, bad positions and value extremes, then random
// command mixes, with random gaps on the command side and stalls on the
// result side.
// ----------------------------------------------------------------------------
module tb_shifting_array_list;
    import sal_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;

    // expected outcome of one command
    typedef struct {
        sal_status_t              status;
        logic                     found;
        logic [COUNT_W-1:0]       count;
        logic signed [WORD_W-1:0] read_value;
    } list_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_cmd = CMD_SEARCH;
    logic signed [WORD_W-1:0]   s_value = '0;
    logic [POS_W-1:0]           s_position = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic                       m_found;
    logic [COUNT_W-1:0]         m_count;
    logic signed [WORD_W-1:0]   m_read_value;

    // predictor state: list contents and entry count
    logic signed [WORD_W-1:0]   list_words [0:LIST_DEPTH-1];
    int                         list_count = 0;

    list_result_t               pending_results [$];
    int                         mismatch_count = 0;
    bit                         src_gaps_on = 1'b1;
    bit                         sink_stalls_on = 1'b1;

    shifting_array_list #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_value(s_value),
        .s_position(s_position),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_found(m_found),
        .m_count(m_count),
        .m_read_value(m_read_value)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // apply one command to the predicted list and return its result
    function automatic list_result_t apply_list_cmd(input sal_cmd_t cmd,
            input logic signed [WORD_W-1:0] word, input logic [POS_W-1:0] pos);
        list_result_t r;
        int at;
        r.status = STAT_OK;
        r.found = 1'b0;
        r.read_value = '0;
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                if (list_count >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (cmd == CMD_INS_FRONT) begin
                        at = 0;
                    end else if (cmd == CMD_INS_BACK) begin
                        at = list_count;
                    end else begin
                        at = int'(pos);
                    end
                    if (at > list_count) begin
                        r.status = STAT_BADPOS;
                    end else begin
                        for (int i = list_count; i > at; i--) begin
                            list_words[i] = list_words[i-1];
                        end
                        list_words[at] = word;
                        list_count++;
                    end
                end
            end
            CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_AT: begin
                if (list_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    if (cmd == CMD_REM_FRONT) begin
                        at = 0;
                    end else if (cmd == CMD_REM_BACK) begin
                        at = list_count - 1;
                    end else begin
                        at = int'(pos);
                    end
                    if (at >= list_count) begin
                        r.status = STAT_BADPOS;
                    end else begin
                        for (int i = at; i + 1 < list_count; i++) begin
                            list_words[i] = list_words[i+1];
                        end
                        list_count--;
                    end
                end
            end
            CMD_SEARCH: begin
                for (int i = 0; i < list_count; i++) begin
                    if (list_words[i] == word) begin
                        r.found = 1'b1;
                    end
                end
            end
            default: begin
                if (list_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (int'(pos) >= list_count) begin
                    r.status = STAT_BADPOS;
                end else begin
                    r.read_value = list_words[int'(pos)];
                end
            end
        endcase
        r.count = list_count[COUNT_W-1:0];
        return r;
    endfunction

    // one command transfer; prediction is taken at the accepting edge
    task automatic send_cmd(input sal_cmd_t cmd, input logic signed [WORD_W-1:0] word,
            input logic [POS_W-1:0] pos);
        int gap;
        gap = src_gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_value <= word;
        s_position <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_list_cmd(cmd, word, pos));
    endtask

    // result side back-pressure
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            n = sink_stalls_on ? idle_len() : 0;
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : check_results
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                        m_status, want.status));
                end
                if (m_found !== want.found) begin
                    report_mismatch($sformatf("found got %b want %b",
                        m_found, want.found));
                end
                if (m_count !== want.count) begin
                    report_mismatch($sformatf("count got %0d want %0d",
                        m_count, want.count));
                end
                if (m_read_value !== want.read_value) begin
                    report_mismatch($sformatf("read_value got %0d want %0d",
                        m_read_value, want.read_value));
                end
            end
        end
    end

    // random word: small pool for duplicates, extremes, or anything
    function automatic logic signed [WORD_W-1:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return $signed($urandom_range(0, 6)) - 3;
        end
        if (r == 3) begin
            return 32'sh8000_0000;
        end
        if (r == 4) begin
            return 32'sh7fff_ffff;
        end
        return $urandom;
    endfunction

    // random position; valid range is 0..limit, limit may be -1
    function automatic logic [POS_W-1:0] random_pos(input int limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80 && limit >= 0) begin
            return POS_W'($urandom_range(0, limit));
        end
        if (r < 97 && limit < LIST_DEPTH) begin
            return POS_W'($urandom_range(limit + 1, LIST_DEPTH));
        end
        return POS_W'($urandom_range(0, 127));
    endfunction

    // random command stream with given insert and remove weights
    task automatic run_random(input int n_items, input int ins_pct, input int rem_pct);
        int r;
        sal_cmd_t cmd;
        logic signed [WORD_W-1:0] word;
        logic [POS_W-1:0] pos;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_INS_FRONT;
                    1: cmd = CMD_INS_BACK;
                    default: cmd = CMD_INS_AT;
                endcase
            end else if (r < ins_pct + rem_pct) begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_REM_FRONT;
                    1: cmd = CMD_REM_BACK;
                    default: cmd = CMD_REM_AT;
                endcase
            end else begin
                cmd = $urandom_range(0, 1) ? CMD_SEARCH : CMD_READ;
            end
            word = random_word();
            // searches hit a stored word about half the time
            if (cmd == CMD_SEARCH && list_count > 0 && $urandom_range(0, 1)) begin
                word = list_words[$urandom_range(0, list_count - 1)];
            end
            if (cmd == CMD_INS_AT) begin
                pos = random_pos(list_count);
            end else begin
                pos = random_pos(list_count - 1);
            end
            send_cmd(cmd, word, pos);
        end
    endtask

    // read, remove and search commands on an empty list, and an insert at a bad position
    task automatic test_empty_list();
        send_cmd(CMD_READ, 0, 0);
        send_cmd(CMD_REM_FRONT, 0, 0);
        send_cmd(CMD_REM_BACK, 0, 0);
        send_cmd(CMD_REM_AT, 0, 5);
        send_cmd(CMD_SEARCH, 0, 0);
        send_cmd(CMD_INS_AT, 1, 1);
    endtask

    // value extremes, append by position, bad positions, hits and misses
    task automatic test_positions_and_extremes();
        send_cmd(CMD_INS_AT, 32'sh7fff_ffff, 0);
        send_cmd(CMD_INS_FRONT, 32'sh8000_0000, 0);
        send_cmd(CMD_INS_BACK, 0, 0);
        send_cmd(CMD_INS_BACK, -1, 0);
        send_cmd(CMD_INS_AT, 32'sh5555_5555, 2);
        send_cmd(CMD_INS_AT, 7, 6);
        send_cmd(CMD_INS_AT, 32'shaaaa_aaaa, 5);
        send_cmd(CMD_READ, 0, 0);
        send_cmd(CMD_READ, 0, 5);
        send_cmd(CMD_READ, 0, 6);
        send_cmd(CMD_READ, 0, 127);
        send_cmd(CMD_SEARCH, 32'sh8000_0000, 0);
        send_cmd(CMD_SEARCH, 12345, 0);
        send_cmd(CMD_REM_AT, 0, 6);
        send_cmd(CMD_REM_AT, 0, 2);
        send_cmd(CMD_REM_FRONT, 0, 0);
        send_cmd(CMD_REM_BACK, 0, 0);
        send_cmd(CMD_READ, 0, 64);
    endtask

    // insert-heavy traffic that reaches and sits at a full list
    task automatic test_fill_to_full();
        run_random(200, 75, 10);
    endtask

    // balanced traffic with both sides always ready
    task automatic test_mixed_back_to_back();
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        run_random(200, 38, 38);
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // remove-heavy traffic that drains to and sits at an empty list
    task automatic test_drain_to_empty();
        run_random(200, 10, 70);
    endtask

    // balanced traffic with gaps and stalls
    task automatic test_mixed_with_idle();
        run_random(200, 40, 40);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        list_count = 0;
        @(posedge aclk);
        test_empty_list();
        test_positions_and_extremes();
        test_fill_to_full();
        test_mixed_back_to_back();
        test_drain_to_empty();
        test_mixed_with_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LIST_DEPTH + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
